### hdl/fmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmh_pkg
// Commands, result status codes and the result word for the frequency
// max-heap counter.
// ----------------------------------------------------------------------------
package fmh_pkg;

   // commands on req_command
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_TOPK   = 2'd2;

   // status codes on rsp_status
   localparam logic [2:0] STAT_COUNTED = 3'd0;
   localparam logic [2:0] STAT_ADDED   = 3'd1;
   localparam logic [2:0] STAT_DROPPED = 3'd2;
   localparam logic [2:0] STAT_SEARCH  = 3'd3;
   localparam logic [2:0] STAT_TOPK    = 3'd4;

   // most result words one top-k command may give
   localparam logic [6:0] MAX_RESULTS = 7'd64;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [31:0] result_key;
      logic [31:0] result_count;
      logic        last;
   } rsp_word_type;

endpackage

### hdl/fmh_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmh_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmh_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

### hdl/fmh_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmh_out
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module fmh_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  fmh_pkg::rsp_word_type load_word,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fmh_pkg::rsp_word_type rsp_word
);

   import fmh_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // load only when free, so a stalled word holds
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

### hdl/frequency_max_heap_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_max_heap_counter_unit
// Word frequency counter kept as a binary max-heap of (key, count) entries.
// ----------------------------------------------------------------------------
// Entries live in one memory of CAPACITY words {key, count}, in heap order
// by count. Every memory access goes through its single read port (with
// registered read data) and single write port, and that port sets the rate.
// Search scans the stored entries in slot order and stops early on a hit;
// insert takes the same scan, then climbs the heap from the hit or new slot,
// through a read state and a compare state per level; a dropped insert (store
// full, key absent) ends after the scan. Top-k emits each word after one full
// selection pass over the memory, picking the next entry after the previous
// pick in (count descending, slot ascending) order. Top-k with nothing to
// emit gives a single empty word; command 3 gives no result. The request
// side is stalled while an item is in work; the finished result waits in
// an output register, so the next item can be taken before it is read.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module frequency_max_heap_counter_unit #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 32,
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_word_key,
   input  logic [6:0]  req_top_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_result_key,
   output logic [31:0] rsp_result_count,
   output logic        rsp_last
);

   import fmh_pkg::*;

   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int TOT_BITS   = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS = KEY_BITS + COUNT_BITS;
   localparam int KW         = (TOT_BITS > 7) ? TOT_BITS : 7;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOT_BITS-1:0]   TOT_FULL = TOT_BITS'(CAPACITY);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN     = 7'b0000010,
      S_SIFT_RD  = 7'b0000100,
      S_SIFT_CMP = 7'b0001000,
      S_RESP     = 7'b0010000,
      S_TK_SCAN  = 7'b0100000,
      S_TK_EMIT  = 7'b1000000
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [TOT_BITS-1:0] total_ff, total_in;
   logic                rd_vld_ff, rd_vld_in;

   // working registers
   logic [1:0]            cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [6:0]            want_ff, want_in;
   logic [TOT_BITS-1:0]   scan_ff, scan_in;
   logic [IDX_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_BITS-1:0]   pos_ff, pos_in;
   logic [IDX_BITS-1:0]   par_ff, par_in;
   logic [KEY_BITS-1:0]   mov_key_ff, mov_key_in;
   logic [COUNT_BITS-1:0] mov_cnt_ff, mov_cnt_in;
   rsp_word_type          res_ff, res_in;
   logic                  best_have_ff, best_have_in;
   logic [KEY_BITS-1:0]   best_key_ff, best_key_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0] prev_cnt_ff, prev_cnt_in;
   logic [IDX_BITS-1:0]   prev_idx_ff, prev_idx_in;
   logic                  first_ff, first_in;
   logic [6:0]            emitted_ff, emitted_in;

   // memory port
   logic [IDX_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [KEY_BITS-1:0]   rd_key;
   logic [COUNT_BITS-1:0] rd_cnt;

   // output register port
   logic         out_load;
   rsp_word_type out_word;
   logic         out_free;
   rsp_word_type rsp_word;

   // helpers
   logic [KEY_BITS-1:0]   req_key;
   logic [6:0]            want_cap;
   logic [KW-1:0]         want_ext;
   logic [KW-1:0]         total_ext;
   logic [6:0]            want_k;
   logic                  scan_more;
   logic                  scan_done;
   logic [IDX_BITS-1:0]   par_calc;
   logic [COUNT_BITS-1:0] inc_cnt;
   logic                  eligible;
   logic [6:0]            emitted_next;

   assign rd_key = rd_data[ENTRY_BITS-1:COUNT_BITS];
   assign rd_cnt = rd_data[COUNT_BITS-1:0];

   assign req_key   = KEY_BITS'(req_word_key);
   assign want_cap  = (req_top_count > MAX_RESULTS) ? MAX_RESULTS : req_top_count;
   assign want_ext  = KW'(want_cap);
   assign total_ext = KW'(total_ff);
   assign want_k    = (want_ext < total_ext) ? want_cap : 7'(total_ff);

   assign scan_more = (scan_ff != total_ff);
   assign scan_done = !scan_more && !rd_vld_ff;
   assign par_calc  = (pos_ff - IDX_BITS'(1)) >> 1;
   assign inc_cnt   = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
   assign eligible  = first_ff || (rd_cnt < prev_cnt_ff) ||
                      ((rd_cnt == prev_cnt_ff) && (rd_idx_ff > prev_idx_ff));
   assign emitted_next = emitted_ff + 7'd1;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      rd_vld_in    = 1'b0;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      want_in      = want_ff;
      scan_in      = scan_ff;
      rd_idx_in    = scan_ff[IDX_BITS-1:0];
      pos_in       = pos_ff;
      par_in       = par_ff;
      mov_key_in   = mov_key_ff;
      mov_cnt_in   = mov_cnt_ff;
      res_in       = res_ff;
      best_have_in = best_have_ff;
      best_key_in  = best_key_ff;
      best_cnt_in  = best_cnt_ff;
      best_idx_in  = best_idx_ff;
      prev_cnt_in  = prev_cnt_ff;
      prev_idx_in  = prev_idx_ff;
      first_in     = first_ff;
      emitted_in   = emitted_ff;
      rd_addr      = scan_ff[IDX_BITS-1:0];
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = {mov_key_ff, mov_cnt_ff};
      out_load     = 1'b0;
      out_word     = res_ff;

      // advance the read stream in the scan states
      if ((state_ff == S_SCAN) || (state_ff == S_TK_SCAN)) begin
         if (scan_more) begin
            rd_vld_in = 1'b1;
            scan_in   = scan_ff + TOT_BITS'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               key_in  = req_key;
               want_in = want_k;
               scan_in = '0;
               unique case (req_command) inside
                  CMD_INSERT, CMD_SEARCH: begin
                     state_in = S_SCAN;
                  end
                  CMD_TOPK: begin
                     if (want_k == 7'd0) begin
                        res_in   = '{status: STAT_TOPK, found: 1'b0, result_key: '0,
                                     result_count: '0, last: 1'b1};
                        state_in = S_RESP;
                     end else begin
                        first_in     = 1'b1;
                        best_have_in = 1'b0;
                        emitted_in   = 7'd0;
                        state_in     = S_TK_SCAN;
                     end
                  end
                  default: begin
                     // unused command: drop it
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (rd_vld_ff && (rd_key == key_ff)) begin
               rd_vld_in = 1'b0;
               if (cmd_ff == CMD_SEARCH) begin
                  res_in   = '{status: STAT_SEARCH, found: 1'b1, result_key: '0,
                               result_count: '0, last: 1'b1};
                  state_in = S_RESP;
               end else begin
                  mov_key_in = key_ff;
                  mov_cnt_in = inc_cnt;
                  pos_in     = rd_idx_ff;
                  res_in     = '{status: STAT_COUNTED, found: 1'b0, result_key: '0,
                                 result_count: 32'(inc_cnt), last: 1'b1};
                  state_in   = S_SIFT_RD;
               end
            end else if (scan_done) begin
               if (cmd_ff == CMD_SEARCH) begin
                  res_in   = '{status: STAT_SEARCH, found: 1'b0, result_key: '0,
                               result_count: '0, last: 1'b1};
                  state_in = S_RESP;
               end else if (total_ff == TOT_FULL) begin
                  res_in   = '{status: STAT_DROPPED, found: 1'b0, result_key: '0,
                               result_count: '0, last: 1'b1};
                  state_in = S_RESP;
               end else begin
                  mov_key_in = key_ff;
                  mov_cnt_in = COUNT_BITS'(1);
                  pos_in     = IDX_BITS'(total_ff);
                  total_in   = total_ff + TOT_BITS'(1);
                  res_in     = '{status: STAT_ADDED, found: 1'b0, result_key: '0,
                                 result_count: 32'd1, last: 1'b1};
                  state_in   = S_SIFT_RD;
               end
            end
         end

         S_SIFT_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_addr  = par_calc;
               par_in   = par_calc;
               state_in = S_SIFT_CMP;
            end
         end

         S_SIFT_CMP: begin
            wr_en = 1'b1;
            if (mov_cnt_ff > rd_cnt) begin
               // parent moves down into the hole, the hole climbs
               wr_data  = rd_data;
               pos_in   = par_ff;
               state_in = S_SIFT_RD;
            end else begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_TK_SCAN: begin
            if (rd_vld_ff && eligible && (!best_have_ff || (rd_cnt > best_cnt_ff))) begin
               best_have_in = 1'b1;
               best_key_in  = rd_key;
               best_cnt_in  = rd_cnt;
               best_idx_in  = rd_idx_ff;
            end
            if (scan_done) begin
               state_in = S_TK_EMIT;
            end
         end

         S_TK_EMIT: begin
            out_word = '{status: STAT_TOPK, found: 1'b1, result_key: 32'(best_key_ff),
                         result_count: 32'(best_cnt_ff), last: (emitted_next == want_ff)};
            if (out_free) begin
               out_load     = 1'b1;
               prev_cnt_in  = best_cnt_ff;
               prev_idx_in  = best_idx_ff;
               first_in     = 1'b0;
               emitted_in   = emitted_next;
               best_have_in = 1'b0;
               scan_in      = '0;
               state_in     = (emitted_next == want_ff) ? S_IDLE : S_TK_SCAN;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         total_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      want_ff      <= want_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      pos_ff       <= pos_in;
      par_ff       <= par_in;
      mov_key_ff   <= mov_key_in;
      mov_cnt_ff   <= mov_cnt_in;
      res_ff       <= res_in;
      best_have_ff <= best_have_in;
      best_key_ff  <= best_key_in;
      best_cnt_ff  <= best_cnt_in;
      best_idx_ff  <= best_idx_in;
      prev_cnt_ff  <= prev_cnt_in;
      prev_idx_ff  <= prev_idx_in;
      first_ff     <= first_in;
      emitted_ff   <= emitted_in;
   end

   fmh_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_BITS)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   fmh_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_word (out_word),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_status       = rsp_word.status;
   assign rsp_found        = rsp_word.found;
   assign rsp_result_key   = rsp_word.result_key;
   assign rsp_result_count = rsp_word.result_count;
   assign rsp_last         = rsp_word.last;

endmodule

### hdl/fmh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmh_checker
// Port-level checks on the result channel of the frequency counter.
// ----------------------------------------------------------------------------
module fmh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_found,
   input logic [31:0] rsp_result_key,
   input logic [31:0] rsp_result_count,
   input logic        rsp_last
);

   import fmh_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found) &&
      $stable(rsp_result_key) && $stable(rsp_result_count) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // insert results: single word, no key, no found flag
   a_insert_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STAT_COUNTED) || (rsp_status == STAT_ADDED) ||
      (rsp_status == STAT_DROPPED)) |-> rsp_last && !rsp_found && (rsp_result_key == 32'd0))
      else $error("malformed insert result");

   // search results: single word with zero key and count
   a_search_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_SEARCH) |->
      rsp_last && (rsp_result_key == 32'd0) && (rsp_result_count == 32'd0))
      else $error("malformed search result");

   // an empty top-k answer is the only word of its command
   a_topk_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_TOPK) && !rsp_found |->
      rsp_last && (rsp_result_key == 32'd0) && (rsp_result_count == 32'd0))
      else $error("malformed empty top-k result");

endmodule

bind frequency_max_heap_counter_unit fmh_checker u_checker (.*);

### tb/tb_frequency_max_heap_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_max_heap_counter_unit
// Self-checking bench for the frequency max-heap counter: a queue-fed driver
// and a checking monitor, with a heap model predicting every result word.
// ----------------------------------------------------------------------------
module tb_frequency_max_heap_counter_unit;
   import fmh_pkg::*;

   // command value the block must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int HEAP_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 380;
   localparam int POOL_SIZE    = 96;   // more keys than slots, so the store fills
   localparam int TAIL_ITEMS   = 40;   // no idling on either side for the last items
   localparam int DRAIN_CYCLES = 300;  // covers a full scan plus sift at 64 entries
   localparam int CLK_HALF     = 6;

   typedef struct {
      logic [1:0]  command;
      logic [31:0] word_key;
      logic [6:0]  top_count;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_INSERT;
   logic [31:0] req_word_key = '0;
   logic [6:0]  req_top_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_found;
   logic [31:0] rsp_result_key;
   logic [31:0] rsp_result_count;
   logic        rsp_last;

   req_item_type pending_items[$];
   rsp_word_type expected_words[$];

   // heap model: same slot layout as the block keeps
   logic [31:0] heap_key   [0:HEAP_DEPTH-1];
   logic [31:0] heap_count [0:HEAP_DEPTH-1];
   int          heap_fill = 0;

   int   mismatch_count = 0;
   logic tail_phase = 1'b0;
   int   idle_left = 0;
   int   stall_left = 0;

   frequency_max_heap_counter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_word_key     (req_word_key),
      .req_top_count    (req_top_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_result_key   (rsp_result_key),
      .rsp_result_count (rsp_result_count),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Heap model
   // ------------------------------------------------------------------------
   function automatic rsp_word_type make_word(logic [2:0] status, logic found,
                                              logic [31:0] key, logic [31:0] count,
                                              logic last);
      rsp_word_type w;
      w.status       = status;
      w.found        = found;
      w.result_key   = key;
      w.result_count = count;
      w.last         = last;
      return w;
   endfunction

   // append one word to the expected stream
   task automatic queue_expected(rsp_word_type w);
      expected_words.insert(expected_words.size(), w);
   endtask

   // scan in slot order, as the block does; -1 when absent
   function automatic int heap_find(logic [31:0] key);
      for (int i = 0; i < heap_fill; i++)
         if (heap_key[i] == key)
            return i;
      return -1;
   endfunction

   // climb while strictly larger than the parent
   task automatic heap_sift_up(int pos);
      int          up;
      logic [31:0] tk;
      logic [31:0] tc;
      while (pos > 0) begin
         up = (pos - 1) / 2;
         if (!(heap_count[pos] > heap_count[up]))
            break;
         tk = heap_key[pos];   heap_key[pos]   = heap_key[up];   heap_key[up]   = tk;
         tc = heap_count[pos]; heap_count[pos] = heap_count[up]; heap_count[up] = tc;
         pos = up;
      end
   endtask

   // Apply one accepted word to the model and queue the result words it causes.
   task automatic heap_predict(logic [1:0] command, logic [31:0] key, logic [6:0] want);
      int          at;
      int          k;
      int          best;
      logic [31:0] c;
      logic [HEAP_DEPTH-1:0] taken;
      case (command)
         CMD_INSERT: begin
            at = heap_find(key);
            if (at >= 0) begin
               // saturate at the count ceiling, then climb
               if (heap_count[at] != '1)
                  heap_count[at] = heap_count[at] + 1;
               c = heap_count[at];
               heap_sift_up(at);
               queue_expected(make_word(STAT_COUNTED, 1'b0, '0, c, 1'b1));
            end else if (heap_fill >= HEAP_DEPTH) begin
               queue_expected(make_word(STAT_DROPPED, 1'b0, '0, '0, 1'b1));
            end else begin
               heap_key[heap_fill]   = key;
               heap_count[heap_fill] = 32'd1;
               heap_fill++;
               heap_sift_up(heap_fill - 1);
               queue_expected(make_word(STAT_ADDED, 1'b0, '0, 32'd1, 1'b1));
            end
         end
         CMD_SEARCH: begin
            queue_expected(make_word(STAT_SEARCH, heap_find(key) >= 0, '0, '0, 1'b1));
         end
         CMD_TOPK: begin
            k = int'(want);
            if (k > int'(MAX_RESULTS))
               k = int'(MAX_RESULTS);
            if (k > heap_fill)
               k = heap_fill;
            if (k == 0) begin
               queue_expected(make_word(STAT_TOPK, 1'b0, '0, '0, 1'b1));
            end else begin
               taken = '0;
               // selection: highest count, ties to the lower slot
               for (int e = 0; e < k; e++) begin
                  best = -1;
                  for (int i = 0; i < heap_fill; i++)
                     if (!taken[i] && (best < 0 || heap_count[i] > heap_count[best]))
                        best = i;
                  taken[best] = 1'b1;
                  queue_expected(make_word(STAT_TOPK, 1'b1, heap_key[best],
                                           heap_count[best], e == k - 1));
               end
            end
         end
         default: ;  // unused command: no state change, no result
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Driver: pop pending items, hold each until accepted, idle in short bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_item_type next_item;
      logic         fire;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else begin
         fire = req_valid && !req_stall;
         // predict at acceptance, so the model sees words in block order
         if (fire)
            heap_predict(req_command, req_word_key, req_top_count);
         if (!req_valid || fire) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (fire && !tail_phase && $urandom_range(0, 4) == 0) begin
               // start a gap with no valid request
               idle_left <= $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               next_item     = pending_items.pop_front();
               req_valid     <= 1'b1;
               req_command   <= next_item.command;
               req_word_key  <= next_item.word_key;
               req_top_count <= next_item.top_count;
            end
         end
         tail_phase <= pending_items.size() < TAIL_ITEMS;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each accepted result word, stall in short bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type actual;
      rsp_word_type wanted;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            actual = make_word(rsp_status, rsp_found, rsp_result_key,
                               rsp_result_count, rsp_last);
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word status=%0d found=%0b key=%h count=%0d last=%0b",
                        $time, actual.status, actual.found, actual.result_key,
                        actual.result_count, actual.last);
               mismatch_count++;
            end else begin
               wanted = expected_words.pop_front();
               if (actual !== wanted) begin
                  $display("%0t: mismatch expected status=%0d found=%0b key=%h count=%0d last=%0b",
                           $time, wanted.status, wanted.found, wanted.result_key,
                           wanted.result_count, wanted.last);
                  $display("%0t:          actual   status=%0d found=%0b key=%h count=%0d last=%0b",
                           $time, actual.status, actual.found, actual.result_key,
                           actual.result_count, actual.last);
                  mismatch_count++;
               end
            end
         end
         // stall bursts, always followed by an open cycle
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (!rsp_stall && !tail_phase && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   task automatic add_item(logic [1:0] command, logic [31:0] key, logic [6:0] want);
      req_item_type it;
      it.command   = command;
      it.word_key  = key;
      it.top_count = want;
      pending_items.insert(pending_items.size(), it);
   endtask

   initial begin
      logic [31:0] key_pool [0:POOL_SIZE-1];
      logic [31:0] key;
      logic [6:0]  want;
      int          counted;
      int          roll;

      // Directed part. The count ceiling is out of reach at 32 count bits,
      // so saturation is not exercised here.
      add_item(CMD_TOPK,   32'h0,         7'd5);    // empty store
      add_item(CMD_SEARCH, 32'h0,         7'd0);    // absent key
      add_item(CMD_INSERT, 32'h0,         7'd0);
      add_item(CMD_INSERT, 32'hFFFF_FFFF, 7'd0);
      add_item(CMD_INSERT, 32'hFFFF_FFFF, 7'd0);    // count up, climbs to the root
      add_item(CMD_INSERT, 32'h5A5A_A5A5, 7'd0);
      add_item(CMD_INSERT, 32'hFFFF_FFFF, 7'd0);
      add_item(CMD_INSERT, 32'h0,         7'd0);
      add_item(CMD_SEARCH, 32'hFFFF_FFFF, 7'd0);
      add_item(CMD_SEARCH, 32'h1234_5678, 7'd0);
      add_item(CMD_TOPK,   32'h0,         7'd0);    // k zero
      add_item(CMD_TOPK,   32'h0,         7'd2);
      add_item(CMD_TOPK,   32'hFFFF_FFFF, 7'd127);  // k above entry count and cap
      add_item(CMD_UNUSED, 32'hA5A5_5A5A, 7'd127);  // ignored
      add_item(CMD_TOPK,   32'h0,         7'd64);
      add_item(CMD_INSERT, 32'h5A5A_A5A5, 7'd0);    // tie with key zero
      add_item(CMD_TOPK,   32'h0,         7'd3);

      // Random part: skewed pool picks build up uneven counts and fill the
      // store; fully random keys cover every key bit and get dropped when full.
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
         else
            key = $urandom;
         if ($urandom_range(0, 7) == 0)
            want = 7'($urandom_range(0, 127));
         else
            want = 7'($urandom_range(0, 12));
         roll = $urandom_range(0, 99);
         if (roll < 62) begin
            add_item(CMD_INSERT, key, want);
            counted++;
         end else if (roll < 84) begin
            add_item(CMD_SEARCH, key, want);
            counted++;
         end else if (roll < 97) begin
            add_item(CMD_TOPK, key, want);
            counted++;
         end else begin
            add_item(CMD_UNUSED, key, want);  // noise, not counted
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for the last word to go in and every result to come back
      while (pending_items.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #(80_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

### frequency_max_heap_counter_unit.f
hdl/fmh_pkg.sv
hdl/fmh_store.sv
hdl/fmh_out.sv
hdl/frequency_max_heap_counter_unit.sv
hdl/fmh_checker.sv
tb/tb_frequency_max_heap_counter_unit.sv
